/* hdl/polynomial_sample_correction_unit_defines.svh */
// ----------------------------------------------------------------------------
// Polynomial sample correction: assertion macros
// Shared check macros, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_SAMPLE_CORRECTION_UNIT_DEFINES_SVH
`define POLYNOMIAL_SAMPLE_CORRECTION_UNIT_DEFINES_SVH

// Same-cycle implication check
`define PSC_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psc check failed");

// Next-cycle implication check
`define PSC_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psc next-cycle check failed");

`endif

/* hdl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Widths, register codes and shared types of the polynomial correction unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

	localparam int MAX_DEGREE = 9;
	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int SUM_W      = PROD_W - FRAC_BITS + 1;
	localparam int NUM_COEF   = MAX_DEGREE + 1;
	localparam int NUM_PAIRS  = (NUM_COEF + 1) / 2;
	localparam int DEG_W      = 4;
	localparam int IDX_W      = 3;
	localparam int CFG_W      = 64;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0]  SAT_MAX = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0]  SAT_MIN = -(SUM_W'(64'sd1 <<< (DATA_W - 1)));
	localparam logic [DATA_W-1:0]        COEF_ONE = DATA_W'(1) << FRAC_BITS;
	localparam logic [DEG_W-1:0]         DEG_MIN = DEG_W'(1);
	localparam logic [DEG_W-1:0]         DEG_MAX = DEG_W'(MAX_DEGREE);

	typedef enum logic [IDX_W-1:0] {
		REG_DEGREE      = 3'd0,
		REG_COEF_PAIR_0 = 3'd1,
		REG_COEF_PAIR_1 = 3'd2,
		REG_COEF_PAIR_2 = 3'd3,
		REG_COEF_PAIR_3 = 3'd4,
		REG_COEF_PAIR_4 = 3'd5
	} cfg_reg_t;

	typedef logic [NUM_COEF-1:0][DATA_W-1:0] coef_arr_t;

	// Beat travelling from one Horner cell to the next
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] acc;
		logic signed [DATA_W-1:0] x;
		logic                     ovf;
		logic                     last;
	} cell_bus_t;

endpackage

`default_nettype wire

/* hdl/psc_in_if.sv */
// ----------------------------------------------------------------------------
// psc_in_if
// Sample channel: valid/ready with one pixel sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psc_in_if import psc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;
	logic                     last_in;

	modport source (output valid, output sample, output last_in, input ready);
	modport sink (input valid, input sample, input last_in, output ready);
endinterface

`default_nettype wire

/* hdl/psc_out_if.sv */
// ----------------------------------------------------------------------------
// psc_out_if
// Result channel: valid/ready with one corrected sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psc_out_if import psc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] corrected;
	logic                     overflowed;
	logic                     last_out;

	modport source (output valid, output corrected, output overflowed, output last_out,
		input ready);
	modport sink (input valid, input corrected, input overflowed, input last_out,
		output ready);
endinterface

`default_nettype wire

/* hdl/psc_cfg.sv */
// ----------------------------------------------------------------------------
// psc_cfg
// Configuration registers: clamped degree and five coefficient pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_cfg import psc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	output logic      [DEG_W-1:0] degree,
	output coef_arr_t             coefs
);

	logic [DEG_W-1:0]                  degree_q;
	logic [NUM_PAIRS-1:0][CFG_W-1:0]   pairs_q;
	logic [DEG_W-1:0]                  deg_clamped;
	logic [DEG_W-1:0]                  deg_raw;

	// Clamp degree into 1..MAX_DEGREE
	always_comb begin
		deg_raw = wr_data[DEG_W-1:0];
		if (deg_raw < DEG_MIN) begin
			deg_clamped = DEG_MIN;
		end else if (deg_raw > DEG_MAX) begin
			deg_clamped = DEG_MAX;
		end else begin
			deg_clamped = deg_raw;
		end
	end

	// Reset to the identity: c1 = 1.0 in the upper half of pair 0, all else 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEG_MIN;
			pairs_q  <= {{((NUM_PAIRS-1)*CFG_W){1'b0}}, COEF_ONE, {DATA_W{1'b0}}};
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_DEGREE:      degree_q   <= deg_clamped;
				REG_COEF_PAIR_0: pairs_q[0] <= wr_data;
				REG_COEF_PAIR_1: pairs_q[1] <= wr_data;
				REG_COEF_PAIR_2: pairs_q[2] <= wr_data;
				REG_COEF_PAIR_3: pairs_q[3] <= wr_data;
				REG_COEF_PAIR_4: pairs_q[4] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_COEF; i++) begin
			coefs[i] = pairs_q[i / 2][(i % 2) * DATA_W +: DATA_W];
		end
	end

	assign degree = degree_q;

endmodule

`default_nettype wire

/* hdl/psc_cell.sv */
// ----------------------------------------------------------------------------
// psc_cell
// One Horner step: multiply, round half up, add coefficient, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_cell import psc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              active,
	input  wire logic [DATA_W-1:0] coef,
	input  wire cell_bus_t         bus_i,
	output cell_bus_t              bus_o
);

	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [DATA_W-1:0] x_s1;
	logic                     ovf_s1;
	logic                     last_s1;
	logic                     vld_s2;
	logic signed [DATA_W-1:0] acc_s2;
	logic signed [DATA_W-1:0] x_s2;
	logic                     ovf_s2;
	logic                     last_s2;

	logic signed [PROD_W-1:0] biased;
	logic signed [PROD_W-1:0] shifted;
	logic signed [SUM_W-1:0]  sum;
	logic signed [DATA_W-1:0] acc_next;
	logic                     sat;

	// Stage 1: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= bus_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(bus_i.acc) * PROD_W'(bus_i.x);
			x_s1    <= bus_i.x;
			ovf_s1  <= bus_i.ovf;
			last_s1 <= bus_i.last;
		end
	end

	// Stage 2: round, add, saturate; idle cells load their own coefficient
	always_comb begin
		biased  = prod_s1 + ROUND_HALF;
		shifted = biased >>> FRAC_BITS;
		sum     = shifted[SUM_W-1:0] + SUM_W'($signed(coef));
		sat     = 1'b0;
		if (sum > SAT_MAX) begin
			acc_next = SAT_MAX[DATA_W-1:0];
			sat      = 1'b1;
		end else if (sum < SAT_MIN) begin
			acc_next = SAT_MIN[DATA_W-1:0];
			sat      = 1'b1;
		end else begin
			acc_next = sum[DATA_W-1:0];
		end
		if (!active) begin
			acc_next = $signed(coef);
			sat      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2  <= acc_next;
			x_s2    <= x_s1;
			ovf_s2  <= ovf_s1 | sat;
			last_s2 <= last_s1;
		end
	end

	assign bus_o = {vld_s2, acc_s2, x_s2, ovf_s2, last_s2};

endmodule

`default_nettype wire

/* hdl/polynomial_sample_correction_unit.sv */
// ----------------------------------------------------------------------------
// polynomial_sample_correction_unit
// Per-sample polynomial correction by Horner's rule in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one signed Q16.16 pixel sample and a last flag per beat.
//   results : source channel, corrected sample, overflow flag and last flag per beat.
//   wr_en / wr_index / wr_data : register writes (degree, five coefficient pairs);
//   write only while no beat is in flight.
// Each beat passes every cell, whatever the configured degree: the chain always
// has nine cells of two stages each (multiply, then round/add/saturate).
// Throughput is one sample per cycle unless the receiver stalls; each cell
// owns its own multiplier, so back-to-back beats overlap along the chain. Cells
// for coefficient indices >= degree just load their coefficient as the accumulator.
// Reset clears every stage valid, sets degree to 1 and the coefficients to
// c1 = 1.0, all others 0 (identity). When the receiver stalls with a result
// waiting, the whole chain holds and samples.ready drops in the same cycle;
// nothing is dropped and the waiting result stays on the port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polynomial_sample_correction_unit import psc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	psc_in_if.sink                samples,
	psc_out_if.source             results
);

`include "polynomial_sample_correction_unit_defines.svh"

	logic [DEG_W-1:0]          degree;
	coef_arr_t                 coefs;
	logic                      advance;
	cell_bus_t                 chain [MAX_DEGREE+1];
	logic [MAX_DEGREE-1:0]     active;

	psc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.degree   (degree),
		.coefs    (coefs)
	);

	// Advance the whole chain unless a finished result is held by the receiver
	assign advance       = !chain[MAX_DEGREE].vld || results.ready;
	assign samples.ready = advance;

	// Head of the chain: the accumulator starts at the top coefficient
	always_comb begin
		chain[0].vld  = samples.valid;
		chain[0].acc  = $signed(coefs[MAX_DEGREE]);
		chain[0].x    = samples.sample;
		chain[0].ovf  = 1'b0;
		chain[0].last = samples.last_in;
	end

	// Cell j performs the step for coefficient index MAX_DEGREE-1-j
	for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
		assign active[j] = DEG_W'(MAX_DEGREE - 1 - j) < degree;

		psc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.active (active[j]),
			.coef   (coefs[MAX_DEGREE-1-j]),
			.bus_i  (chain[j]),
			.bus_o  (chain[j+1])
		);
	end

	// Last cell's stage register is the output register
	assign results.valid      = chain[MAX_DEGREE].vld;
	assign results.corrected  = chain[MAX_DEGREE].acc;
	assign results.overflowed = chain[MAX_DEGREE].ovf;
	assign results.last_out   = chain[MAX_DEGREE].last;

	// Degree register never leaves its legal range
	`PSC_CHECK(a_degree_range, 1'b1, (degree >= DEG_MIN) && (degree <= DEG_MAX))
	// An in-range degree write lands unchanged
	`PSC_CHECK_NEXT(a_degree_write,
		wr_en && (wr_index == REG_DEGREE) && (wr_data[DEG_W-1:0] >= DEG_MIN)
			&& (wr_data[DEG_W-1:0] <= DEG_MAX),
		degree == $past(wr_data[DEG_W-1:0]))
	// A stalled chain takes no sample and holds its result
	`PSC_CHECK_NEXT(a_stall_holds, results.valid && !results.ready,
		results.valid && $stable(results.corrected) && $stable(results.overflowed))
	// Cell for the lowest coefficient is always active
	`PSC_CHECK(a_low_cell_active, 1'b1, active[MAX_DEGREE-1])

endmodule

`default_nettype wire
